// ===== design/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int TICK_W = 16;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd100;
    localparam logic [TICK_W-1:0] PHASE_TICKS_MIN = 16'd2;

    // function codes on the command field
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;
    localparam logic [2:0] FUNC_ACK   = 3'd5;
    localparam logic [2:0] FUNC_NINE  = 3'd6;

    localparam logic [3:0] BIT_MSB   = 4'd7;
    localparam logic [3:0] NINE_BITS = 4'd8;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ,
        CMD_ACK,
        CMD_NINE
    } t_cmd;

    typedef enum logic [4:0] {
        PH_IDLE,
        ST_A, ST_B, ST_C,
        SP_A, SP_B, SP_C,
        WR_PRE, WR_LO, WR_HI,
        WA_LO, WA_H1, WA_H2,
        RD_H1, RD_H2, RD_LO,
        RA_LO, RA_H1, RA_H2,
        SA_A, SA_B, SA_C, SA_D, SA_E,
        NC_LO, NC_HI
    } t_phase;

    // classified tick item passed from front to engine
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } t_item;

    // one result per tick
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       peer_acked;
    } t_result;

endpackage

// ===== design/i2cm_front.sv =====
`timescale 1ns / 1ps

module i2cm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [2:0]      i_func,
    input  logic [7:0]      i_tx_byte,
    input  logic            i_ack_level,
    input  logic            i_sda_in,
    output logic            o_full,
    output logic            o_valid,
    output i2cm_pkg::t_item o_item,
    input  logic            i_take
);
    import i2cm_pkg::*;

    t_item      w_item;
    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_wr;

    // classify the command code, unused codes mean no command
    always_comb begin
        w_item.tx_byte   = i_tx_byte;
        w_item.ack_level = i_ack_level;
        w_item.sda_in    = i_sda_in;
        unique case (i_func)
            FUNC_START: w_item.cmd = CMD_START;
            FUNC_STOP:  w_item.cmd = CMD_STOP;
            FUNC_WRITE: w_item.cmd = CMD_WRITE;
            FUNC_READ:  w_item.cmd = CMD_READ;
            FUNC_ACK:   w_item.cmd = CMD_ACK;
            FUNC_NINE:  w_item.cmd = CMD_NINE;
            default:    w_item.cmd = CMD_NONE;
        endcase
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;

    // two-entry item queue
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, i_take};
        end
    end

endmodule

// ===== design/i2cm_engine.sv =====
`timescale 1ns / 1ps

module i2cm_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [i2cm_pkg::TICK_W-1:0]   i_phase_ticks,
    input  logic                          i_valid,
    input  i2cm_pkg::t_item               i_item,
    output logic                          o_take,
    input  logic                          i_out_full,
    output logic                          o_wr,
    output i2cm_pkg::t_result             o_result
);
    import i2cm_pkg::*;

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [3:0]        r_bit_index, n_bit_index;
    logic [7:0]        r_shift, n_shift;
    logic              r_ack_latch, n_ack_latch;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic [7:0]        r_rx, n_rx;
    logic              r_acked, n_acked;

    logic [TICK_W-1:0] w_full;
    logic [TICK_W-1:0] w_half;
    logic [TICK_W-1:0] w_seg_len;
    logic [TICK_W:0]   w_tick_inc;
    logic              w_seg_end;
    logic              w_bit_zero;
    logic [3:0]        w_bit_dec;
    logic              w_drv;
    logic              w_done;

    assign o_take = i_valid && !i_out_full;
    assign o_wr   = o_take;

    // segment length: full phase, or its halves around the sample point
    always_comb begin
        w_full = (i_phase_ticks < PHASE_TICKS_MIN) ? PHASE_TICKS_MIN : i_phase_ticks;
        w_half = w_full >> 1;
        unique case (r_phase)
            WA_H1, RD_H1, RA_H1: w_seg_len = w_half;
            WA_H2, RD_H2, RA_H2: w_seg_len = w_full - w_half;
            default:             w_seg_len = w_full;
        endcase
    end

    assign w_tick_inc = {1'b0, r_tick} + {{TICK_W{1'b0}}, 1'b1};
    assign w_seg_end  = (r_phase != PH_IDLE) && (w_tick_inc >= {1'b0, w_seg_len});
    assign w_bit_zero = (r_bit_index == 4'd0);
    assign w_bit_dec  = r_bit_index - 4'd1;
    assign w_drv      = ~r_ack_latch;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (r_phase == PH_IDLE) begin
            unique case (i_item.cmd)
                CMD_START: n_phase = ST_A;
                CMD_STOP:  n_phase = SP_A;
                CMD_WRITE: n_phase = WR_PRE;
                CMD_READ:  n_phase = RD_H1;
                CMD_ACK:   n_phase = SA_A;
                CMD_NINE:  n_phase = NC_LO;
                default:   n_phase = PH_IDLE;
            endcase
        end else if (w_seg_end) begin
            unique case (r_phase)
                ST_A:    n_phase = ST_B;
                ST_B:    n_phase = ST_C;
                SP_A:    n_phase = SP_B;
                SP_B:    n_phase = SP_C;
                WR_PRE:  n_phase = WR_LO;
                WR_LO:   n_phase = WR_HI;
                WR_HI:   n_phase = w_bit_zero ? WA_LO : WR_LO;
                WA_LO:   n_phase = WA_H1;
                WA_H1:   n_phase = WA_H2;
                RD_H1:   n_phase = RD_H2;
                RD_H2:   n_phase = RD_LO;
                RD_LO:   n_phase = w_bit_zero ? RA_LO : RD_H1;
                RA_LO:   n_phase = RA_H1;
                RA_H1:   n_phase = RA_H2;
                SA_A:    n_phase = SA_B;
                SA_B:    n_phase = SA_C;
                SA_C:    n_phase = SA_D;
                SA_D:    n_phase = SA_E;
                NC_LO:   n_phase = NC_HI;
                NC_HI:   n_phase = w_bit_zero ? PH_IDLE : NC_LO;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // line levels, counters and data registers
    always_comb begin
        n_tick      = r_tick;
        n_bit_index = r_bit_index;
        n_shift     = r_shift;
        n_ack_latch = r_ack_latch;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_rx        = r_rx;
        n_acked     = r_acked;
        if (r_phase == PH_IDLE) begin
            if (i_item.cmd != CMD_NONE) begin
                n_ack_latch = i_item.ack_level;
                n_tick      = '0;
            end
            unique case (i_item.cmd)
                CMD_START: begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                end
                CMD_STOP: n_sda = 1'b0;
                CMD_WRITE: begin
                    n_shift     = i_item.tx_byte;
                    n_bit_index = BIT_MSB;
                end
                CMD_READ: begin
                    n_shift     = 8'd0;
                    n_bit_index = BIT_MSB;
                    n_scl       = 1'b1;
                    n_sda       = 1'b1;
                end
                CMD_ACK:  n_scl = 1'b0;
                CMD_NINE: n_bit_index = NINE_BITS;
                default: begin
                end
            endcase
        end else if (!w_seg_end) begin
            n_tick = w_tick_inc[TICK_W-1:0];
        end else begin
            n_tick = '0;
            unique case (r_phase)
                ST_A, SP_A: begin
                    n_scl = 1'b1;
                    n_sda = 1'b0;
                end
                ST_B: begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                end
                SP_B, WA_LO, WA_H1, RD_H1: begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                end
                WR_PRE: begin
                    n_scl = 1'b0;
                    n_sda = r_shift[r_bit_index[2:0]];
                end
                WR_LO, NC_LO: n_scl = 1'b1;
                WR_HI: begin
                    n_scl = 1'b0;
                    if (w_bit_zero) begin
                        n_sda = 1'b1;
                    end else begin
                        n_bit_index = w_bit_dec;
                        n_sda       = r_shift[w_bit_dec[2:0]];
                    end
                end
                RD_H2, RA_H2, WA_H2, SA_D: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                end
                RD_LO: begin
                    if (w_bit_zero) begin
                        n_scl = 1'b0;
                        n_sda = w_drv;
                    end else begin
                        n_bit_index = w_bit_dec;
                        n_scl       = 1'b1;
                        n_sda       = 1'b1;
                    end
                end
                RA_LO, RA_H1, SA_B: begin
                    n_scl = 1'b1;
                    n_sda = w_drv;
                end
                SA_A, SA_C: begin
                    n_scl = 1'b0;
                    n_sda = w_drv;
                end
                NC_HI: begin
                    n_scl = 1'b0;
                    if (!w_bit_zero) begin
                        n_bit_index = w_bit_dec;
                    end
                end
                default: begin
                end
            endcase
            // samples taken at the end of a first half-phase; the read byte is latched at the end of RA_H2
            if (r_phase == WA_H1) begin
                n_acked = ~i_item.sda_in;
            end
            if (r_phase == RD_H1) begin
                n_shift = {r_shift[6:0], i_item.sda_in};
            end
            if (r_phase == RA_H2) begin
                n_rx = r_shift;
            end
        end
    end

    assign w_done = w_seg_end && (n_phase == PH_IDLE);

    // result of this tick
    always_comb begin
        o_result.scl_release = n_scl;
        o_result.sda_release = n_sda;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = w_done;
        o_result.rx_byte     = n_rx;
        o_result.peer_acked  = n_acked;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit_index <= 4'd0;
            r_shift     <= 8'd0;
            r_ack_latch <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_rx        <= 8'd0;
            r_acked     <= 1'b0;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bit_index <= n_bit_index;
            r_shift     <= n_shift;
            r_ack_latch <= n_ack_latch;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_rx        <= n_rx;
            r_acked     <= n_acked;
        end
    end

endmodule

// ===== design/i2cm_out_fifo.sv =====
`timescale 1ns / 1ps

module i2cm_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  i2cm_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_empty,
    output i2cm_pkg::t_result o_result,
    input  logic              i_pop
);
    import i2cm_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_rd;
    logic       w_wr;

    assign o_full   = (r_count == 2'd2);
    assign o_empty  = (r_count == 2'd0);
    assign o_result = r_mem[r_rd_ptr];
    assign w_rd     = i_pop && !o_empty;
    assign w_wr     = i_wr && !o_full;

    // two-entry result queue
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

// ===== design/i2c_bit_level_master.sv =====
`timescale 1ns / 1ps

// I2C bit-level master driving open-drain SCL and SDA levels.
// Input channel: one item per bus tick, pushed with push while full is low.
// It carries a command code (none, start, stop, write, read, send ack,
// nine recovery clocks), the byte to write, the ack level and the sampled SDA.
// Result channel: one item per input item, read with pop while empty is low:
// line levels, busy, a done pulse, the last byte read and the peer ack flag.
// Commands that arrive while a command runs are ignored.
// Configuration: one write channel (valid/ready, always ready) sets the number
// of ticks per bus phase; write it only while the block is idle.
// A pushed item waits in the front queue; the engine takes it and writes its result
// into the result queue at the same edge, and the result is then on the result ports.
// Throughput: one item per cycle while the result queue is not full.
// Two-entry queues sit before and after the engine, so push keeps flowing
// while the reader holds off pop until both queues fill; then full rises.
// Reset (synchronous, active low) empties both queues, releases both lines,
// returns the engine to idle and sets the phase length to 100 ticks.

module i2c_bit_level_master (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [2:0]                  i_func,
    input  logic [7:0]                  i_tx_byte,
    input  logic                        i_ack_level,
    input  logic                        i_sda_in,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_scl_release,
    output logic                        o_sda_release,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic [7:0]                  o_rx_byte,
    output logic                        o_peer_acked,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [i2cm_pkg::TICK_W-1:0] i_cfg_phase_ticks
);
    import i2cm_pkg::*;

    logic [TICK_W-1:0] r_phase_ticks;
    logic              w_item_valid;
    t_item             w_item;
    logic              w_take;
    logic              w_out_full;
    logic              w_out_wr;
    t_result           w_eng_result;
    t_result           w_head;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_phase_ticks <= i_cfg_phase_ticks;
        end
    end

    // front: classify and queue ticks
    i2cm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_func      (i_func),
        .i_tx_byte   (i_tx_byte),
        .i_ack_level (i_ack_level),
        .i_sda_in    (i_sda_in),
        .o_full      (full),
        .o_valid     (w_item_valid),
        .o_item      (w_item),
        .i_take      (w_take)
    );

    // back: bus sequencer
    i2cm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_ticks (r_phase_ticks),
        .i_valid       (w_item_valid),
        .i_item        (w_item),
        .o_take        (w_take),
        .i_out_full    (w_out_full),
        .o_wr          (w_out_wr),
        .o_result      (w_eng_result)
    );

    // result queue
    i2cm_out_fifo u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_out_wr),
        .i_result (w_eng_result),
        .o_full   (w_out_full),
        .o_empty  (empty),
        .o_result (w_head),
        .i_pop    (pop)
    );

    assign o_scl_release = w_head.scl_release;
    assign o_sda_release = w_head.sda_release;
    assign o_busy_res    = w_head.busy_res;
    assign o_done_res    = w_head.done_res;
    assign o_rx_byte     = w_head.rx_byte;
    assign o_peer_acked  = w_head.peer_acked;

`ifndef SYNTHESIS
    // a completing command leaves the engine idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_done_res) |-> !o_busy_res)
        else $error("done result reports busy");

    // the engine never writes into a full result queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_wr |-> !w_out_full)
        else $error("result queue overflow");

    // the result queue is empty and the front queue not full right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");
`endif

endmodule
